[design/insort_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared constants and types for the cell chain, its controller and the top.
// ----------------------------------------------------------------------------
package insort_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_out;
      logic                         dropped;
   } rsp_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   // Command from the controller to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         occupied;
      logic                         greater;
   } cell_link_type;

   // Chain status seen by the controller.
   typedef struct packed {
      logic full;
      logic more;
   } chain_status_type;

endpackage

[design/insort_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter cell
// Holds one sorted value; makes room for a new value or shifts toward the head.
// ----------------------------------------------------------------------------
module insort_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  insort_pkg::cell_cmd_type              cmd,
   input  logic signed [insort_pkg::DATA_WIDTH-1:0] new_value,
   input  insort_pkg::cell_link_type             left_link,
   input  insort_pkg::cell_link_type             right_link,
   output insort_pkg::cell_link_type             own_link
);
   import insort_pkg::*;

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;
   logic                         occupied_ff;
   logic                         occupied_in;
   logic                         greater;

   // Strictly greater, so a new value lands after all equal values.
   assign greater = occupied_ff && (new_value < value_ff);

   always_comb begin
      value_in    = value_ff;
      occupied_in = occupied_ff;
      if (cmd.shift) begin
         value_in    = right_link.value;
         occupied_in = right_link.occupied;
      end else if (cmd.insert && (greater || (!occupied_ff && left_link.occupied))) begin
         value_in    = left_link.greater ? left_link.value : new_value;
         occupied_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign own_link.value    = value_ff;
   assign own_link.occupied = occupied_ff;
   assign own_link.greater  = greater;

endmodule

[design/insort_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter controller
// Switches between filling the chain and draining it to the result channel.
// ----------------------------------------------------------------------------
module insort_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_last_in,
   input  logic                         rsp_stall,
   input  insort_pkg::chain_status_type status,
   output logic                         req_stall,
   output logic                         rsp_valid,
   output logic                         dropped,
   output insort_pkg::cell_cmd_type     cmd
);
   import insort_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      overflow_ff;
   logic      overflow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      req_stall   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_FILL: begin
            if (req_valid) begin
               // A request arriving at a full chain is discarded.
               cmd.insert  = !status.full;
               overflow_in = overflow_ff | status.full;
               if (req_last_in) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            req_stall = 1'b1;
            rsp_valid = 1'b1;
            cmd.shift = !rsp_stall;
            if (!rsp_stall && !status.more) begin
               state_in    = ST_FILL;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   assign dropped = overflow_ff;

endmodule

[design/insertion_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter
// Stable ascending sort of signed sets in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//   Channel   Direction   Payload                               Flow control
//   req_      in          value, last_in                        req_valid / req_stall
//   rsp_      out         sorted_value, last_out, dropped       rsp_valid / rsp_stall
//
// While filling, one request is taken every cycle; every cell compares the new
// value with its own in parallel and the chain opens a slot in that cycle.
// After the last request of a set, the held values drain from the head cell;
// req_stall stays high until the final result is taken. Reset is synchronous
// and empties the chain. A stalled result holds because the chain shifts only
// when the head value is taken.
// ----------------------------------------------------------------------------
module insertion_sorter (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  insort_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output insort_pkg::rsp_type rsp_data
);
   import insort_pkg::*;

   cell_cmd_type     cmd;
   chain_status_type status;
   cell_link_type    links [DEPTH];
   logic [DEPTH-1:0] occupied;
   logic             dropped;

   insort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last_in (req_data.last_in),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .dropped     (dropped),
      .cmd         (cmd)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;

      if (i == 0) begin : g_head
         // The head always accepts a new value when it is empty.
         assign left_link = '{value: '0, occupied: 1'b1, greater: 1'b0};
      end else begin : g_body
         assign left_link = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_link = '{value: '0, occupied: 1'b0, greater: 1'b0};
      end else begin : g_inner
         assign right_link = links[i+1];
      end

      insort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_value  (req_data.value),
         .left_link  (left_link),
         .right_link (right_link),
         .own_link   (links[i])
      );

      assign occupied[i] = links[i].occupied;
   end

   assign status.full = occupied[DEPTH-1];
   assign status.more = occupied[1];

   assign rsp_data.sorted_value = links[0].value;
   assign rsp_data.last_out     = !occupied[1];
   assign rsp_data.dropped      = dropped;

`ifndef SYNTHESIS
   // The held values always fill the chain from the head without gaps.
   assert property (@(posedge clock) disable iff (reset)
      (occupied & (occupied + DEPTH'(1))) == '0)
      else $error("chain occupancy is not a contiguous prefix");

   // A result is offered only from an occupied head cell.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occupied[0])
      else $error("result offered from an empty head cell");

   // Taking the last request of a set starts the drain in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.last_in) |=> rsp_valid)
      else $error("set did not start draining");

   // After the final result is taken the chain is empty and idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_out) |=> (!rsp_valid && occupied == '0))
      else $error("chain not empty after the final result");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter testbench
// Sends sets of signed values with random idling on both channels, predicts
// the sorted output of every set and checks each result in arrival order.
// ----------------------------------------------------------------------------
module testbench;

   import insort_pkg::*;

   // Tracks the set being filled and the sorted results that are still due.
   class sorted_set_tracker;
      logic signed [DATA_WIDTH-1:0] held_values[$];
      logic                         set_overflowed;
      rsp_type                      due_results[$];
      int                           errors;

      function new();
         set_overflowed = 1'b0;
         errors = 0;
      endfunction

      function void note_request(req_type item);
         int pos;
         rsp_type outcome;
         if (held_values.size() >= DEPTH) begin
            set_overflowed = 1'b1;
         end else begin
            // Stable: the new value goes after every equal value already held.
            pos = held_values.size();
            while (pos > 0 && item.value < held_values[pos - 1]) begin
               pos--;
            end
            held_values.insert(pos, item.value);
         end
         if (item.last_in) begin
            for (int k = 0; k < held_values.size(); k++) begin
               outcome.sorted_value = held_values[k];
               outcome.last_out     = (k == held_values.size() - 1);
               outcome.dropped      = set_overflowed;
               due_results.push_back(outcome);
            end
            held_values.delete();
            set_overflowed = 1'b0;
         end
      endfunction

      function void check_result(rsp_type seen);
         rsp_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result: value %0d, last %0b, dropped %0b",
                     $time, seen.sorted_value, seen.last_out, seen.dropped);
            errors++;
            return;
         end
         want = due_results.pop_front();
         if (seen.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                     $time, want.sorted_value, seen.sorted_value);
            errors++;
         end
         if (seen.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, want.last_out, seen.last_out);
            errors++;
         end
         if (seen.dropped !== want.dropped) begin
            $display("%0t: dropped mismatch: expected %0b, actual %0b",
                     $time, want.dropped, seen.dropped);
            errors++;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int idle_pct;
   int stall_pct;
   int quiet_cycles = 0;

   sorted_set_tracker tracker = new();

   insertion_sorter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_result(rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drives one request and returns at the edge where it is accepted.
   task automatic send_request(input logic signed [DATA_WIDTH-1:0] value,
                               input logic last_in);
      req_type item;
      item.value   = value;
      item.last_in = last_in;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) begin
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Sender holds off until every due result has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(3))
         0: return $signed($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(4))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0000_0000;
               3: return -32'sd1;
               default: return 32'sh8000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_set(input int size);
      for (int k = 0; k < size; k++) begin
         send_request(pick_value(), k == size - 1);
      end
   endtask

   initial begin
      int sent;
      int size;
      int set_index;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idle_pct  = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Field extremes in one set.
      send_request(32'sh0000_0000, 1'b0);
      send_request(-32'sd1, 1'b0);
      send_request(32'sh7fff_ffff, 1'b0);
      send_request(32'sh8000_0000, 1'b0);
      send_request(32'sd1, 1'b1);
      // Sets of a single value.
      send_request(32'sh8000_0000, 1'b1);
      send_request(32'sh7fff_ffff, 1'b1);
      // Equal values must leave in arrival order.
      send_request(32'sd3, 1'b0);
      send_request(32'sd3, 1'b0);
      send_request(-32'sd3, 1'b0);
      send_request(32'sd3, 1'b0);
      send_request(-32'sd3, 1'b1);
      // Descending input is the worst case for the shifting.
      send_request(32'sd5, 1'b0);
      send_request(32'sd4, 1'b0);
      send_request(32'sd3, 1'b0);
      send_request(32'sd2, 1'b0);
      send_request(32'sd1, 1'b1);
      send_request(-32'sd2, 1'b0);
      send_request(-32'sd1, 1'b0);
      send_request(32'sd0, 1'b0);
      send_request(32'sd1, 1'b1);
      send_request(32'sh5555_5555, 1'b0);
      send_request(32'shaaaa_aaaa, 1'b1);
      wait_for_drain();

      // A full store, one more than full, where the last request is the
      // dropped one, and a set that loses several values.
      send_random_set(DEPTH);
      send_random_set(DEPTH + 1);
      send_random_set(DEPTH + 7);
      wait_for_drain();

      sent = 0;
      set_index = 0;
      while (sent < RANDOM_ITEMS) begin
         case ((set_index / 6) % 5)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            3: begin idle_pct = 14; stall_pct = 14; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         if ($urandom_range(24) == 0) begin
            size = $urandom_range(DEPTH + 12, DEPTH - 4);
         end else begin
            size = $urandom_range(12, 1);
         end
         send_random_set(size);
         sent += size;
         set_index++;
         if (set_index % 20 == 0) begin
            wait_for_drain();
         end
      end

      idle_pct  = 0;
      stall_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
